>>> rtl/pcmtm_pkg.sv
package pcmtm_pkg;

  localparam int FIELD_W = 24;
  localparam int BYTE_W = 8;

  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_MAP     = 1'b1
  } op_t;

  typedef enum logic {
    MODE_SAT = 1'b0,
    MODE_LIN = 1'b1
  } mode_t;

  typedef struct packed {
    logic                op;
    logic                first;
    logic [FIELD_W-1:0]  red_in;
    logic [FIELD_W-1:0]  green_in;
    logic [FIELD_W-1:0]  blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
    logic [BYTE_W-1:0] alpha_out;
  } pix_out_t;

  // one queued map job: masked raw values and the maxima they divide by
  typedef struct packed {
    logic                lin;
    logic [FIELD_W-1:0]  r;
    logic [FIELD_W-1:0]  g;
    logic [FIELD_W-1:0]  b;
    logic [FIELD_W-1:0]  mr;
    logic [FIELD_W-1:0]  mg;
    logic [FIELD_W-1:0]  mb;
  } job_t;

endpackage

>>> rtl/pcmtm_front.sv
module pcmtm_front
  import pcmtm_pkg::*;
#(
  parameter int VAL_BITS = 24
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  pix_in_t in_data,
  input  logic    mode,
  output logic    job_valid,
  input  logic    job_ready,
  output job_t    job
);

  logic [FIELD_W-1:0] max_red, max_green, max_blue;
  logic [FIELD_W-1:0] mask, r, g, b, br, bg, bb;
  logic               full;
  job_t               slot;

  assign mask = (VAL_BITS >= FIELD_W) ? '1 : FIELD_W'((64'd1 << VAL_BITS) - 64'd1);
  assign r = in_data.red_in & mask;
  assign g = in_data.green_in & mask;
  assign b = in_data.blue_in & mask;
  assign br = in_data.first ? '0 : max_red;
  assign bg = in_data.first ? '0 : max_green;
  assign bb = in_data.first ? '0 : max_blue;

  // single-entry queue; map items wait here, measure items never enter
  assign in_ready = !full || job_ready;
  assign job_valid = full;
  assign job = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      max_red <= '0;
      max_green <= '0;
      max_blue <= '0;
    end else begin
      if (in_valid && in_ready && in_data.op == OP_MAP) full <= 1'b1;
      else if (job_ready) full <= 1'b0;
      if (in_valid && in_ready) begin
        if (in_data.op == OP_MEASURE) begin
          max_red <= (r > br) ? r : br;
          max_green <= (g > bg) ? g : bg;
          max_blue <= (b > bb) ? b : bb;
        end else begin
          slot <= '{lin: mode, r: r, g: g, b: b, mr: max_red, mg: max_green, mb: max_blue};
        end
      end
    end
  end

endmodule

>>> rtl/pcmtm_back.sv
module pcmtm_back
  import pcmtm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  output logic     job_ready,
  input  job_t     job,
  output logic     out_valid,
  input  logic     out_ready,
  output pix_out_t out_data
);

  localparam int NUM_W = FIELD_W + BYTE_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [NUM_W-1:0]   nr, ng, nb;
  logic [FIELD_W:0]   rr, rg, rb;
  logic [FIELD_W-1:0] dr, dg, db;
  logic [NUM_W-1:0]   qr, qg, qb;
  logic [NUM_W-1:0]   sr, sg, sb;
  logic [2:0]         use_div;
  logic [FIELD_W:0]   tr, tg, tb;

  function automatic logic [BYTE_W-1:0] clamp(input logic [NUM_W-1:0] v);
    clamp = (v > NUM_W'(255)) ? 8'hff : v[BYTE_W-1:0];
  endfunction

  function automatic logic [NUM_W-1:0] times255(input logic [FIELD_W-1:0] v);
    times255 = (NUM_W'(v) << 8) - NUM_W'(v);
  endfunction

  // restoring division, one quotient bit per channel per cycle
  assign tr = {rr[FIELD_W-1:0], nr[NUM_W-1]};
  assign tg = {rg[FIELD_W-1:0], ng[NUM_W-1]};
  assign tb = {rb[FIELD_W-1:0], nb[NUM_W-1]};

  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            nr <= times255(job.r);
            ng <= times255(job.g);
            nb <= times255(job.b);
            sr <= times255(job.r) >> FRAC_BITS;
            sg <= times255(job.g) >> FRAC_BITS;
            sb <= times255(job.b) >> FRAC_BITS;
            dr <= job.mr;
            dg <= job.mg;
            db <= job.mb;
            use_div <= {job.lin && job.mr != '0, job.lin && job.mg != '0,
                        job.lin && job.mb != '0};
            rr <= '0;
            rg <= '0;
            rb <= '0;
            cnt <= CNT_W'(NUM_W);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rr <= (tr >= {1'b0, dr}) ? tr - {1'b0, dr} : tr;
          rg <= (tg >= {1'b0, dg}) ? tg - {1'b0, dg} : tg;
          rb <= (tb >= {1'b0, db}) ? tb - {1'b0, db} : tb;
          nr <= {nr[NUM_W-2:0], 1'b0};
          ng <= {ng[NUM_W-2:0], 1'b0};
          nb <= {nb[NUM_W-2:0], 1'b0};
          qr <= {qr[NUM_W-2:0], tr >= {1'b0, dr}};
          qg <= {qg[NUM_W-2:0], tg >= {1'b0, dg}};
          qb <= {qb[NUM_W-2:0], tb >= {1'b0, db}};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_data.red_out = clamp(use_div[2] ? qr : sr);
    out_data.green_out = clamp(use_div[1] ? qg : sg);
    out_data.blue_out = clamp(use_div[0] ? qb : sb);
    out_data.alpha_out = 8'hff;
  end

endmodule

>>> rtl/per_channel_max_tone_mapper.sv
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    pix_in_t
// out      out  out_valid/out_ready  pix_out_t
// cfg      in   cfg_valid/cfg_ready  mode bit
// measure items update the maxima in the front part
// map items go through the back part: loaded in idle, then the bit-serial divider, then output
// one map item can wait in the queue while the divider works
// input stalls while a map item waits in the queue and the back part is busy
// rst is synchronous: maxima zero, mode saturate, queue and output empty
module per_channel_max_tone_mapper
  import pcmtm_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  pix_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pix_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  logic mode;
  logic job_valid, job_ready;
  job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) mode <= MODE_SAT;
    else if (cfg_valid) mode <= cfg_data;
  end

  pcmtm_front #(.VAL_BITS(INT_BITS + FRAC_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .mode,
    .job_valid, .job_ready, .job
  );

  pcmtm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .out_data
  );

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.alpha_out == 8'hff) else $error("alpha not 255");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output dropped");
  a_queue: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid) else $error("queued job lost");

endmodule

>>> dv/per_channel_max_tone_mapper_tb.sv
`timescale 1ns / 1ps

module per_channel_max_tone_mapper_tb;
  import pcmtm_pkg::*;

  localparam int FRAC = 16;
  localparam int VALW = 24;
  localparam int MAP_LAT = 40;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RAND = 1300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  per_channel_max_tone_mapper dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  mode_t cur_mode = MODE_SAT;
  logic [VALW-1:0] peak_r = '0, peak_g = '0, peak_b = '0;
  pix_out_t pixel_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_long = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [7:0] sat_byte(logic [VALW-1:0] raw);
    logic [63:0] v;
    v = (64'(raw) * 255) >> FRAC;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] tone_byte(logic [VALW-1:0] raw, logic [VALW-1:0] peak);
    logic [63:0] v;
    if (cur_mode == MODE_SAT || peak == 0) return sat_byte(raw);
    v = (64'(raw) * 255) / 64'(peak);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic void absorb_pixel(pix_in_t p);
    pix_out_t o;
    if (p.op == OP_MEASURE) begin
      if (p.first) begin
        peak_r = '0; peak_g = '0; peak_b = '0;
      end
      if (p.red_in > peak_r) peak_r = p.red_in;
      if (p.green_in > peak_g) peak_g = p.green_in;
      if (p.blue_in > peak_b) peak_b = p.blue_in;
    end else begin
      o.red_out = tone_byte(p.red_in, peak_r);
      o.green_out = tone_byte(p.green_in, peak_g);
      o.blue_out = tone_byte(p.blue_in, peak_b);
      o.alpha_out = 8'd255;
      pixel_q.push_back(o);
    end
  endfunction

  // monitor on rising edge
  always @(posedge clk) begin
    pix_out_t exp_px;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) absorb_pixel(in_data);
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output transfer %h", out_data);
        end else begin
          exp_px = pixel_q.pop_front();
          if (exp_px !== out_data) begin
            errors++;
            if (errors <= 10) $display("mismatch exp %h got %h", exp_px, out_data);
          end
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    int hold;
    if (rst) out_ready <= 1'b0;
    else if (hold_long) begin
      out_ready <= 1'b0;
      for (hold = 0; hold < 300; hold++) @(negedge clk);
      hold_long = 1'b0;
    end else if (stim_done) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_pixel(pix_in_t p);
    in_data <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  task automatic drain_pixels();
    int k;
    drop_valid();
    while (pixel_q.size() != 0) @(negedge clk);
    for (k = 0; k < MAP_LAT; k++) @(negedge clk);
  endtask

  task automatic write_mode(mode_t m);
    drain_pixels();
    cfg_data <= m;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALW-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return VALW'($urandom_range(0, 1 << FRAC));
      3: return VALW'($urandom_range(0, 4 << FRAC));
      default: return VALW'($urandom);
    endcase
  endfunction

  function automatic pix_in_t rand_pixel(logic op, logic fst);
    pix_in_t p;
    p.op = op;
    p.first = fst;
    p.red_in = rand_val();
    p.green_in = rand_val();
    p.blue_in = rand_val();
    return p;
  endfunction

  // directed rows: op, first, r, g, b, expected rgb (only where the check flag is set), check flag
  typedef struct {
    logic op;
    logic first;
    logic [VALW-1:0] r, g, b;
    logic [7:0] er, eg, eb;
    bit typed;
  } row_t;

  row_t rows[$] = '{
    '{OP_MAP,     1'b0, 24'h000000, 24'h000000, 24'h000000, 8'd0,   8'd0,   8'd0,   1'b1},
    '{OP_MAP,     1'b1, 24'hFFFFFF, 24'h010000, 24'h00FFFF, 8'd255, 8'd255, 8'd254, 1'b1},
    '{OP_MAP,     1'b0, 24'h008000, 24'h000101, 24'h000100, 8'd127, 8'd0,   8'd0,   1'b1},
    '{OP_MEASURE, 1'b1, 24'h020000, 24'h000000, 24'hFFFFFF, 8'd0,   8'd0,   8'd0,   1'b0},
    '{OP_MEASURE, 1'b0, 24'h010000, 24'h000000, 24'h000001, 8'd0,   8'd0,   8'd0,   1'b0},
    '{OP_MAP,     1'b0, 24'h020000, 24'h000000, 24'h000000, 8'd255, 8'd0,   8'd0,   1'b1}
  };

  row_t lin_rows[$] = '{
    '{OP_MAP,     1'b0, 24'h020000, 24'h000000, 24'hFFFFFF, 8'd255, 8'd0,   8'd255, 1'b1},
    '{OP_MAP,     1'b0, 24'h010000, 24'h010000, 24'h000000, 8'd127, 8'd255, 8'd0,   1'b1},
    '{OP_MAP,     1'b1, 24'h030000, 24'h000101, 24'h7FFFFF, 8'd0,   8'd0,   8'd0,   1'b0},
    '{OP_MEASURE, 1'b1, 24'h000001, 24'h000000, 24'h000003, 8'd0,   8'd0,   8'd0,   1'b0},
    '{OP_MAP,     1'b0, 24'h000001, 24'h000000, 24'h000001, 8'd255, 8'd0,   8'd85,  1'b1},
    '{OP_MAP,     1'b0, 24'hFFFFFF, 24'h00FFFF, 24'h000002, 8'd255, 8'd254, 8'd170, 1'b1},
    '{OP_MEASURE, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd0,   8'd0,   8'd0,   1'b0},
    '{OP_MAP,     1'b0, 24'hFFFFFF, 24'h000000, 24'h800000, 8'd255, 8'd0,   8'd127, 1'b1}
  };

  task automatic walk_rows(ref row_t tbl[$]);
    pix_in_t p;
    foreach (tbl[i]) begin
      p.op = tbl[i].op;
      p.first = tbl[i].first;
      p.red_in = tbl[i].r;
      p.green_in = tbl[i].g;
      p.blue_in = tbl[i].b;
      if (tbl[i].typed &&
          (tone_byte(p.red_in, peak_r) !== tbl[i].er ||
           tone_byte(p.green_in, peak_g) !== tbl[i].eg ||
           tone_byte(p.blue_in, peak_b) !== tbl[i].eb)) begin
        errors++;
        if (errors <= 10) $display("directed row %0d predicts other than table", i);
      end
      send_pixel(p);
    end
  endtask

  // frame streamed twice, with random bursts and gaps
  task automatic send_frame(int npix, ref int sent);
    pix_in_t frame[$];
    pix_in_t p;
    int burst;
    int gap;
    for (int i = 0; i < npix; i++) frame.push_back(rand_pixel(OP_MEASURE, i == 0));
    burst = $urandom_range(1, 12);
    for (int pass = 0; pass < 2; pass++) begin
      foreach (frame[i]) begin
        p = frame[i];
        if (pass == 1) begin
          p.op = OP_MAP;
          p.first = $urandom_range(0, 1);
          if ($urandom_range(0, 15) == 0) p = rand_pixel(OP_MAP, p.first);
        end else if ($urandom_range(0, 31) == 0) begin
          p.first = $urandom_range(0, 1);
        end
        send_pixel(p);
        sent++;
        if (--burst == 0) begin
          burst = $urandom_range(1, 12);
          if ($urandom_range(0, 2) != 0) begin
            drop_valid();
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
          end
        end
      end
    end
  endtask

  initial begin
    int sent;
    pix_in_t p;
    bit long_done;
    long_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    walk_rows(rows);
    write_mode(MODE_LIN);
    walk_rows(lin_rows);
    write_mode(MODE_SAT);

    sent = 0;
    while (sent < N_RAND) begin
      if ($urandom_range(0, 7) == 0)
        write_mode($urandom_range(0, 1) ? MODE_LIN : MODE_SAT);
      if (sent > 300 && !long_done) begin
        long_done = 1'b1;
        hold_long = 1'b1;
        for (int i = 0; i < 20; i++) begin
          send_pixel(rand_pixel(OP_MAP, $urandom_range(0, 1)));
          sent++;
        end
        drain_pixels();
      end
      if ($urandom_range(0, 9) == 0) begin
        p = rand_pixel($urandom_range(0, 1), $urandom_range(0, 1));
        send_pixel(p);
        sent++;
      end else begin
        send_frame($urandom_range(1, 16), sent);
      end
    end
    drop_valid();
    stim_done = 1'b1;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (MAP_LAT * 2) @(negedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
